@@ hdl/lbhl_pkg.sv @@
// shared constants for the lazy bind hash lookup block
// command and status codes, field widths, default table depths; no dependencies
package lbhl_pkg;

    // default table depths
    localparam int HASH_DEPTH_DEF   = 2048;
    localparam int SYM_DEPTH_DEF    = 1024;
    localparam int LINK_DEPTH_DEF   = 512;
    localparam int RESULT_DEPTH_DEF = 512;

    // field widths
    localparam int CMD_W    = 2;
    localparam int HASH_W   = 32;
    localparam int ADDR_W   = 64;
    localparam int SSLOT_W  = 10;
    localparam int LSLOT_W  = 9;
    localparam int RSLOT_W  = 9;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 32;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 104;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CACHED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

@@ hdl/lazy_bind_hash_lookup_top.sv @@
// lazy bind hash lookup: symbol hash table with linear probing and link/result tables
// depends on lbhl_pkg
// Usage:
//   s_ channel takes one command per transfer (insert symbol, map link entry,
//   resolve link entry, clear resolved marks); m_ channel returns exactly one
//   result per command (status, bound address, running binding count).
//   One command is worked on at a time; s_tready is high only while idle.
// Command steps, from the input transfer to the result loaded: map finishes
// on acceptance; clear marks sweeps the resolved marks; resolve reads the link
// entry and its resolved mark and answers a cached entry at once; insert and an
// uncached resolve reduce the hash to a home slot (bit select when HASH_DEPTH is
// a power of two, else reciprocal multiply, remainder, fixup), then visit hash
// slots (one memory read each) and, on a resolve, compare the stored hash of
// each occupied slot.
// The result sits in an output register; a stalled receiver holds the result
// and the block goes on to accept the next command, which waits at its final
// step until the register is taken.
// Reset: a clearing pass over all hash slots and result slots empties the
// hash table and the resolved marks; s_tready stays low during it.
module lazy_bind_hash_lookup_top #(
    parameter int HASH_DEPTH   = lbhl_pkg::HASH_DEPTH_DEF,
    parameter int SYM_DEPTH    = lbhl_pkg::SYM_DEPTH_DEF,
    parameter int LINK_DEPTH   = lbhl_pkg::LINK_DEPTH_DEF,
    parameter int RESULT_DEPTH = lbhl_pkg::RESULT_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd, sym_hash, sym_address, sym_slot, link_slot, result_slot, zero pad
    input  logic [lbhl_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, bound_address, bind_total, zero pad
    output logic [lbhl_pkg::M_DATA_W-1:0] m_tdata
);
    import lbhl_pkg::*;

    localparam int HIDX = $clog2(HASH_DEPTH);
    localparam int SIDX = $clog2(SYM_DEPTH);
    localparam int LIDX = $clog2(LINK_DEPTH);
    localparam int RIDX = $clog2(RESULT_DEPTH);
    localparam int VW   = $clog2(SYM_DEPTH + 1);
    localparam int MAXD = (HASH_DEPTH > RESULT_DEPTH) ? HASH_DEPTH : RESULT_DEPTH;
    localparam int CW   = $clog2(MAXD);
    localparam bit HASH_POW2 = ((HASH_DEPTH & (HASH_DEPTH - 1)) == 0);
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / 64'(HASH_DEPTH));

    typedef enum logic [9:0] {
        S_SWEEP = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_LINK  = 10'b0000000100,
        S_RES   = 10'b0000001000,
        S_VALID = 10'b0000010000,
        S_MOD   = 10'b0000100000,
        S_PROBE = 10'b0001000000,
        S_PCHK  = 10'b0010000000,
        S_SCHK  = 10'b0100000000,
        S_SADDR = 10'b1000000000
    } state_t;

    // one more state for result hand-off kept apart as a flag
    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // input fields
    logic [CMD_W-1:0]   in_cmd;
    logic [HASH_W-1:0]  in_hash;
    logic [ADDR_W-1:0]  in_addr;
    logic [SSLOT_W-1:0] in_ss;
    logic [LSLOT_W-1:0] in_ls;
    logic [RSLOT_W-1:0] in_rs;
    assign in_cmd  = s_tdata[1:0];
    assign in_hash = s_tdata[33:2];
    assign in_addr = s_tdata[97:34];
    assign in_ss   = s_tdata[107:98];
    assign in_ls   = s_tdata[116:108];
    assign in_rs   = s_tdata[125:117];

    // working registers
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [HASH_W-1:0]   key_reg, key_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SIDX-1:0]     ss_reg, ss_next;
    logic [LIDX-1:0]     ls_reg, ls_next;
    logic [RIDX-1:0]     r_reg, r_next;
    logic [SIDX-1:0]     hit_reg, hit_next;
    logic [HIDX-1:0]     idx_reg, idx_next;
    logic [HIDX:0]       n_reg, n_next;
    logic [HASH_W-1:0]   quo_reg, quo_next;
    logic [HASH_W-1:0]   rem_reg, rem_next;
    logic [1:0]          step_reg, step_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                sweep_all_reg, sweep_all_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   baddr_reg, baddr_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    // output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                out_free;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign s_tready = (state_reg == S_IDLE) && !done_reg;

    // memories
    logic [VW-1:0]     hash_mem     [HASH_DEPTH];
    logic [HASH_W-1:0] sym_hash_mem [SYM_DEPTH];
    logic [ADDR_W-1:0] sym_addr_mem [SYM_DEPTH];
    logic [RIDX-1:0]   link_res_mem [LINK_DEPTH];
    logic [SIDX-1:0]   link_sym_mem [LINK_DEPTH];
    logic [ADDR_W-1:0] res_addr_mem [RESULT_DEPTH];
    logic              res_vld_mem  [RESULT_DEPTH];

    logic [VW-1:0]     hash_rd, hash_wd;
    logic [HIDX-1:0]   hash_wa;
    logic              hash_we;
    logic [HASH_W-1:0] sym_hash_rd;
    logic [SIDX-1:0]   sym_ra;
    logic [ADDR_W-1:0] sym_addr_rd;
    logic              sym_we;
    logic [RIDX-1:0]   link_res_rd;
    logic [SIDX-1:0]   link_sym_rd;
    logic              link_we;
    logic [ADDR_W-1:0] res_addr_rd;
    logic              res_vld_rd, res_vld_wd, res_vld_we;
    logic [RIDX-1:0]   res_vld_wa;
    logic              res_addr_we;

    // probe helpers
    logic [SIDX-1:0]       v_sym;
    logic                  v_ok;
    logic                  probe_last;
    logic [HIDX-1:0]       idx_step;
    logic [2*HASH_W-1:0]   recip_prod;
    logic [HASH_W-1:0]     quo_mul;
    logic [HASH_W-1:0]     rem_fold;
    logic                  sweep_last;
    logic                  accept;

    assign accept     = s_tvalid && s_tready;
    assign v_sym      = SIDX'(hash_rd - VW'(1));
    assign v_ok       = (hash_rd != '0) && (32'(hash_rd) <= SYM_DEPTH);
    assign probe_last = (n_reg == (HIDX+1)'(HASH_DEPTH - 1));
    assign idx_step   = (idx_reg == HIDX'(HASH_DEPTH - 1)) ? '0 : idx_reg + HIDX'(1);
    assign sweep_last = sweep_all_reg ? (cnt_reg == CW'(MAXD - 1))
                                      : (cnt_reg == CW'(RESULT_DEPTH - 1));

    // home slot by reciprocal multiply; the estimate is low by at most one
    assign recip_prod = (2*HASH_W)'(key_reg) * (2*HASH_W)'(RECIP);
    assign quo_mul    = quo_reg * HASH_W'(HASH_DEPTH);
    assign rem_fold   = (rem_reg >= HASH_W'(HASH_DEPTH)) ? rem_reg - HASH_W'(HASH_DEPTH)
                                                         : rem_reg;

    // write port selection
    always_comb begin
        hash_we = 1'b0;
        hash_wa = idx_reg;
        hash_wd = VW'(ss_reg) + VW'(1);
        if (state_reg == S_SWEEP) begin
            hash_we = sweep_all_reg && (32'(cnt_reg) < HASH_DEPTH);
            hash_wa = cnt_reg[HIDX-1:0];
            hash_wd = '0;
        end else if (state_reg == S_PCHK) begin
            hash_we = (cmd_reg == CMD_INSERT) && (hash_rd == '0);
        end
    end

    assign sym_we  = (state_reg == S_PCHK) && (cmd_reg == CMD_INSERT) && (hash_rd == '0);
    assign link_we = accept && (in_cmd == CMD_MAP) && (32'(in_ls) < LINK_DEPTH)
                     && (32'(in_ss) < SYM_DEPTH) && (32'(in_rs) < RESULT_DEPTH);
    assign sym_ra  = (state_reg == S_RES) ? link_sym_rd
                   : (state_reg == S_PCHK) ? v_sym : hit_reg;
    assign res_addr_we = (state_reg == S_SADDR);

    always_comb begin
        res_vld_we = 1'b0;
        res_vld_wa = r_reg;
        res_vld_wd = 1'b1;
        if (state_reg == S_SWEEP) begin
            res_vld_we = (32'(cnt_reg) < RESULT_DEPTH);
            res_vld_wa = cnt_reg[RIDX-1:0];
            res_vld_wd = 1'b0;
        end else if (state_reg == S_SADDR) begin
            res_vld_we = 1'b1;
        end
    end

    // hash slot memory
    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[hash_wa] <= hash_wd;
        end
        hash_rd <= hash_mem[idx_reg];
    end

    // symbol stores
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_hash_mem[ss_reg] <= key_reg;
        end
        sym_hash_rd <= sym_hash_mem[sym_ra];
    end

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_addr_mem[ss_reg] <= addr_reg;
        end
        sym_addr_rd <= sym_addr_mem[hit_reg];
    end

    // link tables
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_res_mem[LIDX'(in_ls)] <= RIDX'(in_rs);
            link_sym_mem[LIDX'(in_ls)] <= SIDX'(in_ss);
        end
        link_res_rd <= link_res_mem[ls_reg];
        link_sym_rd <= link_sym_mem[ls_reg];
    end

    // result tables
    always_ff @(posedge aclk) begin
        if (res_addr_we) begin
            res_addr_mem[r_reg] <= sym_addr_rd;
        end
        res_addr_rd <= res_addr_mem[link_res_rd];
    end

    always_ff @(posedge aclk) begin
        if (res_vld_we) begin
            res_vld_mem[res_vld_wa] <= res_vld_wd;
        end
        res_vld_rd <= res_vld_mem[link_res_rd];
    end

    // command sequencer
    always_comb begin
        state_next     = state_reg;
        done_next      = done_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        ss_next        = ss_reg;
        ls_next        = ls_reg;
        r_next         = r_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        sweep_all_next = sweep_all_reg;
        status_next    = status_reg;
        baddr_next     = baddr_reg;
        total_next     = total_reg;

        if (done_reg) begin
            // result waits for the output register
            if (out_free) begin
                done_next = 1'b0;
            end
        end else begin
            unique case (state_reg)
                S_SWEEP: begin
                    cnt_next = cnt_reg + CW'(1);
                    if (sweep_last) begin
                        state_next  = S_IDLE;
                        done_next   = !sweep_all_reg;
                        status_next = ST_DONE;
                        baddr_next  = '0;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cmd_next    = in_cmd;
                        key_next    = in_hash;
                        addr_next   = in_addr;
                        ss_next     = SIDX'(in_ss);
                        ls_next     = LIDX'(in_ls);
                        status_next = ST_DONE;
                        baddr_next  = '0;
                        unique case (in_cmd)
                            CMD_INSERT: begin
                                if (32'(in_ss) < SYM_DEPTH) begin
                                    state_next = S_MOD;
                                    step_next  = 2'd0;
                                end else begin
                                    done_next = 1'b1;
                                end
                            end
                            CMD_MAP: begin
                                done_next = 1'b1;
                            end
                            CMD_RESOLVE: begin
                                if (32'(in_ls) < LINK_DEPTH) begin
                                    state_next = S_LINK;
                                end else begin
                                    status_next = ST_NOT_FOUND;
                                    done_next   = 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                state_next     = S_SWEEP;
                                cnt_next       = '0;
                                sweep_all_next = 1'b0;
                            end
                            default: begin
                                done_next = 1'b1;
                            end
                        endcase
                    end
                end
                S_LINK: begin
                    state_next = S_RES;
                end
                S_RES: begin
                    r_next     = link_res_rd;
                    state_next = S_VALID;
                end
                S_VALID: begin
                    if (res_vld_rd) begin
                        status_next = ST_CACHED;
                        baddr_next  = res_addr_rd;
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                    end else begin
                        key_next   = sym_hash_rd;
                        state_next = S_MOD;
                        step_next  = 2'd0;
                    end
                end
                S_MOD: begin
                    // home slot: low hash bits for a power-of-two depth, else quotient estimate, remainder, final fixup
                    if (HASH_POW2) begin
                        idx_next   = key_reg[HIDX-1:0];
                        n_next     = '0;
                        state_next = S_PROBE;
                    end else begin
                        step_next = step_reg + 2'd1;
                        if (step_reg == 2'd0) begin
                            quo_next = recip_prod[2*HASH_W-1:HASH_W];
                        end else if (step_reg == 2'd1) begin
                            rem_next = key_reg - quo_mul;
                        end else begin
                            idx_next   = HIDX'(rem_fold);
                            n_next     = '0;
                            state_next = S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    state_next = S_PCHK;
                end
                S_PCHK: begin
                    if (hash_rd == '0) begin
                        status_next = (cmd_reg == CMD_INSERT) ? ST_DONE : ST_NOT_FOUND;
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                    end else if ((cmd_reg == CMD_RESOLVE) && v_ok) begin
                        hit_next   = v_sym;
                        state_next = S_SCHK;
                    end else if (probe_last) begin
                        status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                    end else begin
                        idx_next   = idx_step;
                        n_next     = n_reg + (HIDX+1)'(1);
                        state_next = S_PROBE;
                    end
                end
                S_SCHK: begin
                    if (sym_hash_rd == key_reg) begin
                        state_next = S_SADDR;
                    end else if (probe_last) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                    end else begin
                        idx_next   = idx_step;
                        n_next     = n_reg + (HIDX+1)'(1);
                        state_next = S_PROBE;
                    end
                end
                S_SADDR: begin
                    status_next = ST_BOUND;
                    baddr_next  = sym_addr_rd;
                    if (total_reg != '1) begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            sweep_all_reg <= 1'b1;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
            sweep_all_reg <= sweep_all_next;
            total_reg     <= total_next;
            if (done_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        addr_reg   <= addr_next;
        ss_reg     <= ss_next;
        ls_reg     <= ls_next;
        r_reg      <= r_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        status_reg <= status_next;
        baddr_reg  <= baddr_next;
        if (done_reg && out_free) begin
            m_data_reg <= {5'd0, total_reg, baddr_reg, status_reg};
        end
    end

endmodule

@@ hdl/lbhl_checker.sv @@
// port-level checks for the lazy bind hash lookup top level
// depends on lbhl_pkg; bound to lazy_bind_hash_lookup_top
module lbhl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lbhl_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lbhl_pkg::M_DATA_W-1:0] m_tdata
);
    import lbhl_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one command at a time: no transfer in the cycle after one
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a new binding always shows a nonzero count
    a_bound_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_BOUND) |-> m_tdata[98:67] != '0)
        else $error("binding reported with zero count");

    // no address on failing or plain statuses
    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_DONE || m_tdata[2:0] == ST_NOT_FOUND
                     || m_tdata[2:0] == ST_FULL) |-> m_tdata[66:3] == '0)
        else $error("address on status without binding");

endmodule

bind lazy_bind_hash_lookup_top lbhl_checker u_lbhl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/lazy_bind_hash_lookup_top_tb.sv @@
// testbench for lazy_bind_hash_lookup_top: directed and random commands with checked results
// depends on lbhl_pkg and the lazy_bind_hash_lookup_top rtl
`timescale 1ns / 100ps

// predicts every result from the accepted commands and checks the returned transfers
class bind_scoreboard;
    localparam int HD = lbhl_pkg::HASH_DEPTH_DEF;
    localparam int SD = lbhl_pkg::SYM_DEPTH_DEF;
    localparam int LD = lbhl_pkg::LINK_DEPTH_DEF;
    localparam int RD = lbhl_pkg::RESULT_DEPTH_DEF;

    int unsigned   slot_tab [HD];
    bit [31:0]     sym_hash [SD];
    bit [63:0]     sym_addr [SD];
    int unsigned   link_res [LD];
    int unsigned   link_sym [LD];
    bit [63:0]     res_addr [RD];
    bit            res_ok   [RD];
    bit [31:0]     bindings;
    bit [103:0]    pending_results [$];
    int            mismatches;

    function new();
        foreach (slot_tab[i]) slot_tab[i] = 0;
        foreach (res_addr[i]) res_addr[i] = '0;
        foreach (res_ok[i]) res_ok[i] = 0;
        bindings = 0;
        mismatches = 0;
    endfunction

    // walk the probe chain for a name hash, -1 when absent
    function int find_sym(bit [31:0] h);
        int idx;
        idx = h % HD;
        for (int n = 0; n < HD; n++) begin
            if (slot_tab[idx] == 0) return -1;
            if (slot_tab[idx] - 1 < SD && sym_hash[slot_tab[idx] - 1] == h)
                return slot_tab[idx] - 1;
            idx = (idx + 1 >= HD) ? 0 : idx + 1;
        end
        return -1;
    endfunction

    function void note_input(logic [lbhl_pkg::S_DATA_W-1:0] d);
        logic [1:0]  cmd;
        bit [31:0]   nh;
        bit [63:0]   addr;
        int unsigned ss, ls, rs, idx, r;
        bit          placed;
        int          hit;
        bit [2:0]    status;
        bit [63:0]   baddr;
        cmd = d[1:0];
        nh = d[33:2];
        addr = d[97:34];
        ss = 32'(d[107:98]);
        ls = 32'(d[116:108]);
        rs = 32'(d[125:117]);
        status = lbhl_pkg::ST_DONE;
        baddr = '0;
        case (cmd)
            lbhl_pkg::CMD_INSERT: begin
                idx = nh % HD;
                placed = 0;
                for (int n = 0; n < HD; n++) begin
                    if (slot_tab[idx] == 0) begin
                        slot_tab[idx] = ss + 1;
                        placed = 1;
                        break;
                    end
                    idx = (idx + 1 >= HD) ? 0 : idx + 1;
                end
                if (placed) begin
                    sym_hash[ss] = nh;
                    sym_addr[ss] = addr;
                end else begin
                    status = lbhl_pkg::ST_FULL;
                end
            end
            lbhl_pkg::CMD_MAP: begin
                link_sym[ls] = ss;
                link_res[ls] = rs;
            end
            lbhl_pkg::CMD_RESOLVE: begin
                status = lbhl_pkg::ST_NOT_FOUND;
                r = link_res[ls];
                if (res_ok[r]) begin
                    status = lbhl_pkg::ST_CACHED;
                    baddr = res_addr[r];
                end else begin
                    hit = find_sym(sym_hash[link_sym[ls]]);
                    if (hit >= 0) begin
                        res_addr[r] = sym_addr[hit];
                        res_ok[r] = 1;
                        if (bindings != 32'hFFFF_FFFF) bindings++;
                        status = lbhl_pkg::ST_BOUND;
                        baddr = res_addr[r];
                    end
                end
            end
            default: begin
                foreach (res_ok[i]) res_ok[i] = 0;
            end
        endcase
        pending_results.push_back({5'd0, bindings, baddr, status});
    endfunction

    function void check_result(logic [lbhl_pkg::M_DATA_W-1:0] d);
        bit [103:0] want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", d);
            return;
        end
        want = pending_results.pop_front();
        if (d[2:0] !== want[2:0] || d[66:3] !== want[66:3] || d[98:67] !== want[98:67]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: status %0d/%0d addr %h/%h total %0d/%0d",
                         want[2:0], d[2:0], want[66:3], d[66:3], want[98:67], d[98:67]);
        end
    endfunction
endclass

module lazy_bind_hash_lookup_top_tb;
    import lbhl_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;

    bind_scoreboard sb = new();
    bit             gaps_on = 1;
    bit             long_hold_req = 0;
    int             quiet_cycles = 0;

    // symbols and link entries written so far, known at send time
    bit [31:0]   sym_hash_seen [$];
    int unsigned sym_seen [$];
    bit          sym_is_written [SYM_DEPTH_DEF];
    int unsigned link_seen [$];
    bit          link_is_mapped [LINK_DEPTH_DEF];

    lazy_bind_hash_lookup_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("lazy_bind_hash_lookup_top verification failed");
                $finish;
            end
        end
    end

    // result receiver with random and long hold-offs
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 0;
                m_tready <= 0;
                repeat (400) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic send_cmd(logic [1:0] cmd, bit [31:0] nh, bit [63:0] addr,
                            int unsigned ss, int unsigned ls, int unsigned rs);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, rs[8:0], ls[8:0], ss[9:0], addr, nh, cmd};
        do @(posedge aclk); while (!s_tready);
        // bookkeeping for the random generator
        if (cmd == CMD_INSERT) begin
            if (!sym_is_written[ss]) sym_seen.push_back(ss);
            sym_is_written[ss] = 1;
            sym_hash_seen.push_back(nh);
        end else if (cmd == CMD_MAP && !link_is_mapped[ls]) begin
            link_is_mapped[ls] = 1;
            link_seen.push_back(ls);
        end
    endtask

    task automatic insert_sym(bit [31:0] nh, bit [63:0] addr, int unsigned ss);
        send_cmd(CMD_INSERT, nh, addr, ss, $urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    task automatic map_link(int unsigned ss, int unsigned ls, int unsigned rs);
        send_cmd(CMD_MAP, $urandom, {$urandom, $urandom}, ss, ls, rs);
    endtask

    task automatic resolve_link(int unsigned ls);
        send_cmd(CMD_RESOLVE, $urandom, {$urandom, $urandom}, $urandom_range(0, 1023), ls,
                 $urandom_range(0, 511));
    endtask

    task automatic clear_marks();
        send_cmd(CMD_CLEAR, $urandom, {$urandom, $urandom}, $urandom_range(0, 1023),
                 $urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    // random name hash: mostly clustered home slots to force long probe chains
    function automatic bit [31:0] pick_hash();
        bit [31:0] h;
        h = $urandom;
        if ($urandom_range(0, 9) < 2 && sym_hash_seen.size() != 0)
            h = sym_hash_seen[$urandom_range(0, sym_hash_seen.size() - 1)];
        else if ($urandom_range(0, 9) < 7)
            h[10:0] = 11'($urandom_range(0, 255));
        return h;
    endfunction

    initial begin
        int unsigned pick;
        foreach (sym_is_written[i]) sym_is_written[i] = 0;
        foreach (link_is_mapped[i]) link_is_mapped[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, collisions, duplicates, cached and cleared marks
        insert_sym(32'h0000_0000, 64'h0, 0);
        insert_sym(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1023);
        insert_sym(32'h0000_0800, 64'h1234_5678_9ABC_DEF0, 5);
        insert_sym(32'h0000_0800, 64'hAAAA_5555_AAAA_5555, 6);
        insert_sym(32'hFFFF_F7FF, 64'h5555_AAAA_5555_AAAA, 7);
        map_link(0, 0, 0);
        map_link(1023, 511, 511);
        map_link(5, 1, 2);
        map_link(6, 2, 2);
        map_link(7, 3, 3);
        resolve_link(0);
        resolve_link(511);
        resolve_link(511);
        resolve_link(1);
        resolve_link(2);
        resolve_link(3);
        clear_marks();
        resolve_link(2);
        resolve_link(1);
        resolve_link(0);
        wait_drained();

        // random commands, the last part without idling
        for (int i = 0; i < 1250; i++) begin
            if (i == 1050) gaps_on = 0;
            if (i == 300) long_hold_req = 1;
            if (i == 600) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 30 || sym_seen.size() == 0)
                insert_sym(pick_hash(), {$urandom, $urandom}, $urandom_range(0, 1023));
            else if (pick < 55 || link_seen.size() == 0)
                map_link(sym_seen[$urandom_range(0, sym_seen.size() - 1)],
                         $urandom_range(0, 511), $urandom_range(0, 511));
            else if (pick < 95)
                resolve_link(link_seen[$urandom_range(0, link_seen.size() - 1)]);
            else
                clear_marks();
        end
        wait_drained();

        // closing mix: one more insert, clear marks, resolve old and new entries
        insert_sym($urandom, {$urandom, $urandom}, $urandom_range(0, 1023));
        clear_marks();
        resolve_link(link_seen[0]);
        resolve_link(link_seen[link_seen.size() - 1]);
        wait_drained();

        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("lazy_bind_hash_lookup_top verification clean");
        end else begin
            $display("lazy_bind_hash_lookup_top verification failed");
        end
        $finish;
    end
endmodule
